### design/imc_pkg.sv
// Package for the interrupt set/clear/mask register block.
// Holds opcode and register-select codes, fixed field widths and item types.
// No dependencies.
package imc_pkg;

  localparam int OffsetW    = 8;
  localparam int DataW      = 32;
  localparam int LineBitsW  = 6;
  localparam int SelW       = 6;

  localparam logic [DataW-1:0] VERSION_VALUE = 32'h0202_0102;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_RAISE = 2'd2,
    OP_CLEAR = 2'd3
  } imc_op_t;

  localparam logic [SelW-1:0] SEL_MODE    = 6'd0;
  localparam logic [SelW-1:0] SEL_VERSION = 6'd1;
  localparam logic [SelW-1:0] SEL_PENDING = 6'd2;
  localparam logic [SelW-1:0] SEL_MASK    = 6'd3;

  typedef struct packed {
    imc_op_t                opcode;
    logic [OffsetW-1:0]     reg_offset;
    logic [DataW-1:0]       write_data;
    logic [LineBitsW-1:0]   line_bits;
  } imc_item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq_level;
  } imc_result_t;

endpackage

### design/imc_if.sv
// Valid/ready channel interfaces for requests and results.
// Depends on imc_pkg for field widths.
interface imc_req_if import imc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic [OffsetW-1:0]   reg_offset;
  logic [DataW-1:0]     write_data;
  logic [LineBitsW-1:0] line_bits;

  modport source (output valid, output opcode, output reg_offset, output write_data,
                  output line_bits, input ready);
  modport sink (input valid, input opcode, input reg_offset, input write_data,
                input line_bits, output ready);
endinterface

interface imc_rsp_if import imc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic             irq_level;

  modport source (output valid, output read_data, output irq_level, input ready);
  modport sink (input valid, input read_data, input irq_level, output ready);
endinterface

### design/interrupt_mask_register_block_top.sv
// Top level of the interrupt set/clear/mask register block.
// Depends on imc_pkg, imc_if (imc_req_if, imc_rsp_if) and imc_regs.
//
//   channel  direction  payload                                      handshake
//   req      sink       opcode, reg_offset, write_data, line_bits    valid/ready
//   rsp      source     read_data, irq_level                         valid/ready
//
// One item per cycle sustained while rsp is not stalled; the item is registered in the input
// stage, and rsp.valid rises when the result register loads its result.
// The item goes through an input register, the register file update, and a result register.
// rst is synchronous and clears the mode, pending and mask state and both stage valids.
// req.ready drops only when both stages hold items and rsp is stalled.
module interrupt_mask_register_block_top import imc_pkg::*; #(
  parameter int LINE_COUNT = 6
) (
  input logic   clk,
  input logic   rst,
  imc_req_if.sink   req,
  imc_rsp_if.source rsp
);

  logic        stage_valid;
  imc_item_t   stage_item;
  logic        out_valid;
  imc_result_t out_result;
  imc_result_t calc_result;
  logic        advance;

  assign advance   = stage_valid && (!out_valid || rsp.ready);
  assign req.ready = !stage_valid || advance;

  imc_regs #(
    .LINE_COUNT(LINE_COUNT)
  ) u_regs (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (stage_item),
    .result (calc_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (req.ready) stage_valid <= req.valid;
      if (advance) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
    if (req.ready && req.valid) begin
      stage_item.opcode     <= imc_op_t'(req.opcode);
      stage_item.reg_offset <= req.reg_offset;
      stage_item.write_data <= req.write_data;
      stage_item.line_bits  <= req.line_bits;
    end
    if (advance) out_result <= calc_result;
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_data = out_result.read_data;
  assign rsp.irq_level = out_result.irq_level;

endmodule

### design/imc_regs.sv
// Register file: mode, pending and mask state, read mux and request level.
// Depends on imc_pkg.
module imc_regs import imc_pkg::*; #(
  parameter int LINE_COUNT = 6
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  imc_item_t   item,
  output imc_result_t result
);

  localparam int ExtW = (LINE_COUNT > LineBitsW) ? LINE_COUNT : LineBitsW;

  logic [DataW-1:0]      mode_word, mode_word_next;
  logic [LINE_COUNT-1:0] pending_lines, pending_lines_next;
  logic [LINE_COUNT-1:0] enable_mask, enable_mask_next;
  logic [LINE_COUNT-1:0] mask_written;
  logic [ExtW-1:0]       lines_ext;
  logic [LINE_COUNT-1:0] lines;
  logic [SelW-1:0]       sel;
  logic [DataW-1:0]      read_value;

  assign sel       = item.reg_offset[OffsetW-1:2];
  assign lines_ext = ExtW'(item.line_bits);
  assign lines     = lines_ext[LINE_COUNT-1:0];

  always_comb begin
    mask_written = enable_mask;
    for (int i = 0; i < LINE_COUNT; i++) begin
      if (item.write_data[2*i]) mask_written[i] = 1'b0;
      if (item.write_data[2*i+1]) mask_written[i] = 1'b1;
    end
  end

  always_comb begin
    case (sel)
      SEL_MODE:    read_value = mode_word;
      SEL_VERSION: read_value = VERSION_VALUE;
      SEL_PENDING: read_value = DataW'(pending_lines);
      SEL_MASK:    read_value = DataW'(enable_mask);
      default:     read_value = '0;
    endcase
  end

  always_comb begin
    mode_word_next     = mode_word;
    pending_lines_next = pending_lines;
    enable_mask_next   = enable_mask;
    result.read_data   = '0;
    unique case (item.opcode)
      OP_READ: begin
        result.read_data = read_value;
      end
      OP_WRITE: begin
        if (sel == SEL_MODE) mode_word_next = item.write_data;
        if (sel == SEL_MASK) enable_mask_next = mask_written;
      end
      OP_RAISE: begin
        pending_lines_next = pending_lines | lines;
      end
      OP_CLEAR: begin
        pending_lines_next = pending_lines & ~lines;
      end
      default: begin
        result.read_data = '0;
      end
    endcase
    result.irq_level = |(pending_lines_next & enable_mask_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_word     <= '0;
      pending_lines <= '0;
      enable_mask   <= '0;
    end else if (fire) begin
      mode_word     <= mode_word_next;
      pending_lines <= pending_lines_next;
      enable_mask   <= enable_mask_next;
    end
  end

endmodule
